[sv/gcsf_pkg.sv]
// ----------------------------------------------------------------------------
// gcsf_pkg
// Shared types and constants of the channel seepage flux unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gcsf_pkg;

  // Signed width that holds every head, point and perimeter without overflow.
  localparam int W = 36;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 4;

  // Classified edge, handed from the front to the back.
  typedef struct packed {
    logic                gate;      // high point above low point
    logic                use_side;  // perimeter from the side slopes
    logic                neg;       // flow out of the channel
    logic signed [W-1:0] hi;
    logic signed [W-1:0] lim;
    logic signed [W-1:0] direct;
    logic [29:0]         base_half;
    logic [30:0]         slope;
    logic [31:0]         cond;
    logic [34:0]         mag;
    logic [30:0]         len;
    logic [30:0]         thick;
  } fr_t;

endpackage

`default_nettype wire

[sv/gcsf_item_if.sv]
// ----------------------------------------------------------------------------
// gcsf_item_if
// Channel carrying one edge description.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcsf_item_if;
  logic               valid;
  logic               ready;
  logic [30:0]        edge_length;
  logic signed [31:0] mesh_surface_z;
  logic signed [31:0] mesh_bedrock_z;
  logic [30:0]        mesh_pond_depth;
  logic signed [31:0] mesh_water_head;
  logic signed [31:0] bank_z;
  logic signed [31:0] bed_z;
  logic [30:0]        base_width;
  logic [30:0]        side_slope;
  logic [31:0]        bed_conductivity;
  logic [30:0]        bed_thickness;
  logic [30:0]        channel_depth;

  modport source (output valid, edge_length, mesh_surface_z, mesh_bedrock_z,
                  mesh_pond_depth, mesh_water_head, bank_z, bed_z, base_width,
                  side_slope, bed_conductivity, bed_thickness, channel_depth,
                  input ready);
  modport sink (input valid, edge_length, mesh_surface_z, mesh_bedrock_z,
                mesh_pond_depth, mesh_water_head, bank_z, bed_z, base_width,
                side_slope, bed_conductivity, bed_thickness, channel_depth,
                output ready);
endinterface

`default_nettype wire

[sv/gcsf_flux_if.sv]
// ----------------------------------------------------------------------------
// gcsf_flux_if
// Channel carrying one seepage flux result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcsf_flux_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] flow_rate;
  logic               saturated;

  modport source (output valid, flow_rate, saturated, input ready);
  modport sink (input valid, flow_rate, saturated, output ready);
endinterface

`default_nettype wire

[sv/gcsf_front.sv]
// ----------------------------------------------------------------------------
// gcsf_front
// Three-stage classifier: adjusts and clamps the heads, finds the high and
// low points of the wetted perimeter and the head difference.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsf_front import gcsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gcsf_item_if.sink   items,
  output fr_t         fr_data,
  output logic        fr_valid,
  input  logic        fr_ready
);

  typedef struct packed {
    logic signed [W-1:0] head;
    logic signed [W-1:0] bank;
    logic signed [W-1:0] chan;
    logic signed [W-1:0] bedthick;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] rock;
    logic signed [W-1:0] bed;
    logic [29:0]         base_half;
    logic [30:0]         slope;
    logic [31:0]         cond;
    logic [30:0]         len;
    logic [30:0]         thick;
  } fa_t;

  typedef struct packed {
    logic signed [W-1:0] head;
    logic signed [W-1:0] chan;
    logic signed [W-1:0] hi;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] rock;
    logic signed [W-1:0] bed;
    logic [29:0]         base_half;
    logic [30:0]         slope;
    logic [31:0]         cond;
    logic [30:0]         len;
    logic [30:0]         thick;
  } fb_t;

  fa_t  a, a_next;
  fb_t  b, b_next;
  fr_t  c_next;
  logic va, vb;
  logic en;

  logic signed [W-1:0] surf, rock_in, pond, head_in, bank_in, bed_in;
  logic signed [W-1:0] depth, thick_in, h1, dh;

  assign en          = !fr_valid || fr_ready;
  assign items.ready = en;

  // Stage A: pond on the surface, bank raised, channel level, low point.
  always_comb begin
    surf     = W'(items.mesh_surface_z);
    rock_in  = W'(items.mesh_bedrock_z);
    head_in  = W'(items.mesh_water_head);
    bank_in  = W'(items.bank_z);
    bed_in   = W'(items.bed_z);
    pond     = signed'(W'(items.mesh_pond_depth));
    depth    = signed'(W'(items.channel_depth));
    thick_in = signed'(W'(items.bed_thickness));

    a_next.head      = (head_in == surf) ? head_in + pond : head_in;
    a_next.bank      = (bank_in < surf) ? surf : bank_in;
    a_next.chan      = bed_in + depth;
    a_next.bedthick  = bed_in - thick_in;
    a_next.lo        = (bed_in < rock_in) ? rock_in - bed_in : '0;
    a_next.rock      = rock_in;
    a_next.bed       = bed_in;
    a_next.base_half = items.base_width[30:1];
    a_next.slope     = items.side_slope;
    a_next.cond      = items.bed_conductivity;
    a_next.len       = items.edge_length;
    a_next.thick     = (items.bed_thickness == '0) ? 31'd1 : items.bed_thickness;
  end

  // Stage B: clamp the heads for the flow direction and pick the high point.
  always_comb begin
    h1 = (a.head < a.rock) ? a.rock : a.head;
    b_next.head      = a.head;
    b_next.chan      = a.chan;
    b_next.lo        = a.lo;
    b_next.rock      = a.rock;
    b_next.bed       = a.bed;
    b_next.base_half = a.base_half;
    b_next.slope     = a.slope;
    b_next.cond      = a.cond;
    b_next.len       = a.len;
    b_next.thick     = a.thick;
    if (a.head > a.chan) begin
      b_next.chan = (a.chan < a.rock) ? a.rock : a.chan;
      b_next.hi   = (a.bank < a.head) ? a.bank - a.bed : a.head - a.bed;
    end else begin
      b_next.head = (h1 < a.bedthick) ? a.bedthick : h1;
      b_next.hi   = (a.bank < a.chan) ? a.bank - a.bed : a.chan - a.bed;
    end
  end

  // Stage C: head difference, bedrock limit and the perimeter path.
  always_comb begin
    dh = b.head - b.chan;
    c_next.neg       = dh < 0;
    c_next.mag       = (dh < 0) ? 35'(-dh) : 35'(dh);
    c_next.lim       = b.hi + b.bed - b.rock;
    c_next.direct    = b.hi - b.lo;
    c_next.gate      = b.hi > b.lo;
    c_next.use_side  = b.lo == '0;
    c_next.hi        = b.hi;
    c_next.base_half = b.base_half;
    c_next.slope     = b.slope;
    c_next.cond      = b.cond;
    c_next.len       = b.len;
    c_next.thick     = b.thick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      fr_valid <= 1'b0;
    end else if (en) begin
      va       <= items.valid;
      vb       <= va;
      fr_valid <= vb;
    end
    if (en) begin
      a       <= a_next;
      b       <= b_next;
      fr_data <= c_next;
    end
  end

endmodule

`default_nettype wire

[sv/gcsf_queue.sv]
// ----------------------------------------------------------------------------
// gcsf_queue
// Short first-in first-out queue between the classifier and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsf_queue import gcsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  fr_t  wr_data,
  input  logic wr_valid,
  output logic wr_ready,
  output fr_t  rd_data,
  output logic rd_valid,
  input  logic rd_ready
);

  localparam int PW = $clog2(QDEPTH);

  fr_t             mem [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;
  logic            push, pop;

  assign wr_ready = count != (PW+1)'(QDEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

[sv/gcsf_back.sv]
// ----------------------------------------------------------------------------
// gcsf_back
// Arithmetic pipeline: side factor square root, wetted perimeter, the wide
// flux product and the division by the bed thickness, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsf_back import gcsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fr_t        fr_data,
  input  logic       fr_valid,
  output logic       fr_ready,
  gcsf_flux_if.source results
);

  localparam int SQ0 = 4;          // first square root stage
  localparam int DV0 = 43;         // first division stage
  localparam int NS  = 108;        // number of stages, the last one is the output

  typedef struct packed {
    logic                gate;
    logic                use_side;
    logic                neg;
    logic                over;
    logic                sat;
    logic signed [W-1:0] hi;
    logic signed [W-1:0] lim;
    logic signed [W-1:0] direct;
    logic [29:0]         base_half;
    logic [30:0]         slope;
    logic [31:0]         cond;
    logic [34:0]         mag;
    logic [30:0]         len;
    logic [30:0]         thick;
    logic [63:0]         rem;
    logic [31:0]         root;
    logic [63:0]         quo;
    logic [35:0]         perim;
    logic [89:0]         pp0;
    logic [89:0]         pp1;
    logic [89:0]         pp2;
    logic [89:0]         pp3;
    logic [132:0]        prod;
    logic [63:0]         flow;
  } bk_t;

  function automatic bk_t load(input fr_t f);
    bk_t r;
    r           = '0;
    r.gate      = f.gate;
    r.use_side  = f.use_side;
    r.neg       = f.neg;
    r.hi        = f.hi;
    r.lim       = f.lim;
    r.direct    = f.direct;
    r.base_half = f.base_half;
    r.slope     = f.slope;
    r.cond      = f.cond;
    r.mag       = f.mag;
    r.len       = f.len;
    r.thick     = f.thick;
    return r;
  endfunction

  // Work of stage k; k is fixed for each stage, so each stage gets only its
  // own slice of this logic.
  function automatic bk_t step(input int k, input bk_t a);
    bk_t                 r;
    logic [61:0]         sq;
    logic [49:0]         m0, m1;
    logic [53:0]         n0, n1, n2;
    logic [60:0]         q0, q1, q2, q3;
    logic [64:0]         trial;
    logic [63:0]         rs;
    logic [63:0]         dv;
    logic [67:0]         hs;
    logic signed [69:0]  ps, lm, sel;
    int                  i;
    r = a;
    if (k == 0) begin
      sq     = a.slope * a.slope;
      m0     = a.cond * a.mag[17:0];
      m1     = a.cond * a.mag[34:18];
      r.rem  = (64'd1 << 32) + 64'(sq);
      r.root = '0;
      r.pp0  = 90'(m0);
      r.pp1  = 90'(m1);
    end else if (k == 1) begin
      r.prod = 133'(a.pp0) + (133'(a.pp1) << 18);
    end else if (k == 2) begin
      n0    = a.prod[22:0] * a.len;
      n1    = a.prod[45:23] * a.len;
      n2    = 54'(a.prod[66:46]) * 54'(a.len);
      r.pp0 = 90'(n0);
      r.pp1 = 90'(n1);
      r.pp2 = 90'(n2);
    end else if (k == 3) begin
      r.prod = 133'(a.pp0) + (133'(a.pp1) << 23) + (133'(a.pp2) << 46);
    end else if (k < SQ0 + 32) begin
      // One root bit: try (root + 2^i)^2 against the remaining radicand.
      i     = SQ0 + 31 - k;
      trial = (65'(a.root) << (i + 1)) + (65'd1 << (2 * i));
      if ({1'b0, a.rem} >= trial) begin
        r.rem  = 64'({1'b0, a.rem} - trial);
        r.root = a.root | (32'd1 << i);
      end
    end else if (k == SQ0 + 32) begin
      m0    = a.hi[17:0] * a.root;
      m1    = a.hi[35:18] * a.root;
      r.pp0 = 90'(m0);
      r.pp1 = 90'(m1);
    end else if (k == SQ0 + 33) begin
      hs    = 68'(a.pp0) + (68'(a.pp1) << 18);
      r.pp2 = 90'(hs[67:16]) + 90'(a.base_half);
    end else if (k == SQ0 + 34) begin
      ps  = signed'(70'(a.pp2));
      lm  = 70'(a.lim);
      sel = a.use_side ? ((ps > lm) ? lm : ps) : 70'(a.direct);
      r.perim = (!a.gate || sel <= 0) ? '0 : sel[35:0];
    end else if (k == SQ0 + 35) begin
      q0    = a.prod[24:0] * a.perim;
      q1    = a.prod[49:25] * a.perim;
      q2    = a.prod[74:50] * a.perim;
      q3    = 61'(a.prod[97:75]) * 61'(a.perim);
      r.pp0 = 90'(q0);
      r.pp1 = 90'(q1);
      r.pp2 = 90'(q2);
      r.pp3 = 90'(q3);
    end else if (k == SQ0 + 36) begin
      r.pp0 = a.pp0 + (a.pp1 << 25);
      r.pp2 = a.pp2 + (a.pp3 << 25);
    end else if (k == SQ0 + 37) begin
      r.prod = 133'(a.pp0) + (133'(a.pp2) << 50);
    end else if (k == DV0 - 1) begin
      // A quotient of 2^64 or more only needs the top bits against the divisor.
      r.over = a.prod[132:96] >= 37'(a.thick);
      r.rem  = a.prod[127:64];
      r.quo  = '0;
    end else if (k < DV0 + 64) begin
      i  = DV0 + 63 - k;
      dv = {1'b0, a.thick, 32'd0};
      rs = {a.rem[62:0], a.prod[i]};
      if (rs >= dv) begin
        rs       = rs - dv;
        r.quo[i] = 1'b1;
      end
      r.rem = rs;
    end else begin
      r.sat = 1'b0;
      if (a.neg) begin
        if (a.over || a.quo > 64'h8000_0000_0000_0000) begin
          r.flow = 64'h8000_0000_0000_0000;
          r.sat  = 1'b1;
        end else begin
          r.flow = ~a.quo + 64'd1;
        end
      end else begin
        if (a.over || a.quo[63]) begin
          r.flow = 64'h7FFF_FFFF_FFFF_FFFF;
          r.sat  = 1'b1;
        end else begin
          r.flow = a.quo;
        end
      end
    end
    return r;
  endfunction

  bk_t  st [NS];
  logic vld [NS];
  logic en;

  assign en                = !vld[NS-1] || results.ready;
  assign fr_ready          = en;
  assign results.valid     = vld[NS-1];
  assign results.flow_rate = signed'(st[NS-1].flow);
  assign results.saturated = st[NS-1].sat;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= fr_valid;
    if (en) st[0] <= step(0, load(fr_data));
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (en) vld[k] <= vld[k-1];
      if (en) st[k] <= step(k, st[k-1]);
    end
  end

endmodule

`default_nettype wire

[sv/groundwater_channel_seepage_flux_unit.sv]
// ----------------------------------------------------------------------------
// groundwater_channel_seepage_flux_unit
// Seepage flow across one mesh-to-channel edge, one edge per clock while the results channel is ready.
//
// Usage: edge words enter on the items channel, results leave on the results
// channel; both use a valid/ready handshake and a word moves when both are
// high at a rising edge of clk.
// Throughput: one word per cycle with no gaps while results.ready is high.
// Path from an accepted edge to its result being offered: three classifier
// stages, the queue, and 108 datapath stages, set by the 32 square root
// steps and the 64 division steps, one bit per stage.
// Reset (rst, synchronous) empties all stages and the queue; no result is
// offered until new edges arrive.
// When the receiver holds ready low, the datapath freezes with its result
// held; the queue absorbs the classifier's words, then items.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module groundwater_channel_seepage_flux_unit import gcsf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gcsf_item_if.sink    items,
  gcsf_flux_if.source  results
);

  fr_t  f_data, q_data;
  logic f_valid, f_ready, q_valid, q_ready;

  gcsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .fr_data  (f_data),
    .fr_valid (f_valid),
    .fr_ready (f_ready)
  );

  gcsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_data),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  gcsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .fr_data  (q_data),
    .fr_valid (q_valid),
    .fr_ready (q_ready),
    .results  (results)
  );

endmodule

`default_nettype wire

[sim/tb_seepage_flux_expect.sv]
// ----------------------------------------------------------------------------
// Seepage flux predictor
// Computes the expected flow and saturation flag for one channel edge.
// ----------------------------------------------------------------------------
`default_nettype none

package seepage_flux_expect_pkg;

  typedef struct {
    logic [30:0]        edge_length;
    logic signed [31:0] mesh_surface_z;
    logic signed [31:0] mesh_bedrock_z;
    logic [30:0]        mesh_pond_depth;
    logic signed [31:0] mesh_water_head;
    logic signed [31:0] bank_z;
    logic signed [31:0] bed_z;
    logic [30:0]        base_width;
    logic [30:0]        side_slope;
    logic [31:0]        bed_conductivity;
    logic [30:0]        bed_thickness;
    logic [30:0]        channel_depth;
  } edge_word_t;

  typedef struct {
    logic signed [63:0] flow_rate;
    logic               saturated;
  } flux_word_t;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic flux_word_t seepage_flux(input edge_word_t e);
    flux_word_t r;
    longint head, surf, rock, bank, bed, chan, thick, hi, lo, perim, dh, lim;
    logic [63:0] side;
    logic [63:0] slope;
    logic [63:0] mag;
    logic [191:0] prod;
    logic [191:0] quo;
    r.flow_rate = 0;
    r.saturated = 0;
    surf = e.mesh_surface_z;
    rock = e.mesh_bedrock_z;
    head = e.mesh_water_head;
    bank = e.bank_z;
    bed = e.bed_z;
    thick = e.bed_thickness;
    chan = longint'(e.channel_depth) + bed;
    if (head == surf) head = head + longint'(e.mesh_pond_depth);
    if (bank < surf) bank = surf;
    if (head > chan) begin
      if (chan < rock) chan = rock;
      hi = (bank < head) ? bank - bed : head - bed;
    end else begin
      if (head < rock) head = rock;
      if (head < bed - thick) head = bed - thick;
      hi = (bank < chan) ? bank - bed : chan - bed;
    end
    lo = (bed < rock) ? rock - bed : 0;
    if (hi > lo) begin
      if (lo == 0) begin
        slope = 64'(e.side_slope);
        side = floor_sqrt((64'd1 << 32) + slope * slope);
        lim = hi + bed - rock;
        perim = longint'((64'(hi) * side) >> 16) + longint'(e.base_width >> 1);
        if (perim > lim) perim = lim;
      end else begin
        perim = hi - lo;
      end
      dh = head - chan;
      if (dh != 0 && e.bed_conductivity != 0 && e.edge_length != 0 && perim > 0) begin
        mag = (dh < 0) ? 64'(-dh) : 64'(dh);
        prod = 192'(e.bed_conductivity) * 192'(mag) * 192'(e.edge_length)
               * 192'(64'(perim));
        quo = (prod / 192'((thick == 0) ? 1 : thick)) >> 32;
        if (dh > 0) begin
          if (quo > 192'h7FFF_FFFF_FFFF_FFFF) begin
            r.flow_rate = 64'h7FFF_FFFF_FFFF_FFFF;
            r.saturated = 1;
          end else begin
            r.flow_rate = quo[63:0];
          end
        end else begin
          if (quo > 192'h8000_0000_0000_0000) begin
            r.flow_rate = 64'h8000_0000_0000_0000;
            r.saturated = 1;
          end else begin
            r.flow_rate = -quo[63:0];
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Seepage flux unit testbench
// Streams directed and random edge words through the unit under random idling
// on both channels and checks every flux word against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import gcsf_pkg::*;
  import seepage_flux_expect_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  gcsf_item_if items ();
  gcsf_flux_if results ();

  groundwater_channel_seepage_flux_unit DUT (
    .clk(clk), .rst(rst), .items(items), .results(results)
  );

  flux_word_t pending_flux[$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned saturations = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint unsigned cycles = 0;

  initial begin
    items.valid = 0;
    items.edge_length = 0;
    items.mesh_surface_z = 0;
    items.mesh_bedrock_z = 0;
    items.mesh_pond_depth = 0;
    items.mesh_water_head = 0;
    items.bank_z = 0;
    items.bed_z = 0;
    items.base_width = 0;
    items.side_slope = 0;
    items.bed_conductivity = 0;
    items.bed_thickness = 0;
    items.channel_depth = 0;
    results.ready = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at word %0d: %s", checked, what);
    mismatches++;
  endtask

  // Receiver: random stalls, compare each flux word against the oldest prediction.
  always @(negedge clk) begin
    if (!rst) results.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && results.valid && results.ready) begin
      if (pending_flux.size() == 0) begin
        report_mismatch("flux word with no edge pending");
      end else begin
        flux_word_t x;
        x = pending_flux.pop_front();
        if (results.flow_rate !== x.flow_rate)
          report_mismatch($sformatf("flow_rate %0d, expected %0d",
                                    results.flow_rate, x.flow_rate));
        if (results.saturated !== x.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b",
                                    results.saturated, x.saturated));
        if (x.saturated) saturations++;
      end
      checked++;
    end
  end

  // Valid stays high from one word to the next unless the sender idles, so
  // that back-to-back words see a single update of valid per falling edge.
  task automatic send_edge(input edge_word_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 0;
      @(negedge clk);
    end
    items.valid <= 1;
    items.edge_length <= e.edge_length;
    items.mesh_surface_z <= e.mesh_surface_z;
    items.mesh_bedrock_z <= e.mesh_bedrock_z;
    items.mesh_pond_depth <= e.mesh_pond_depth;
    items.mesh_water_head <= e.mesh_water_head;
    items.bank_z <= e.bank_z;
    items.bed_z <= e.bed_z;
    items.base_width <= e.base_width;
    items.side_slope <= e.side_slope;
    items.bed_conductivity <= e.bed_conductivity;
    items.bed_thickness <= e.bed_thickness;
    items.channel_depth <= e.channel_depth;
    do @(posedge clk); while (!items.ready);
    pending_flux.push_back(seepage_flux(e));
    sent++;
    @(negedge clk);
  endtask

  // A plausible geometry around a random datum with small heights.
  function automatic edge_word_t sane_edge();
    edge_word_t e;
    int signed datum;
    datum = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    e.bed_z = datum;
    e.mesh_surface_z = datum + $urandom_range(32'h0008_0000);
    e.bank_z = datum + $urandom_range(32'h0008_0000);
    e.mesh_bedrock_z = datum - $signed($urandom_range(32'h0008_0000))
                       + 32'sh0002_0000;
    e.mesh_water_head = ($urandom_range(3) == 0) ? e.mesh_surface_z :
                        datum + $signed($urandom_range(32'h000C_0000)) - 32'sh0004_0000;
    e.mesh_pond_depth = 31'($urandom_range(32'h0002_0000));
    e.channel_depth = 31'($urandom_range(32'h0004_0000));
    e.base_width = 31'($urandom_range(32'h0020_0000));
    e.side_slope = 31'($urandom_range(32'h0004_0000));
    e.bed_conductivity = $urandom;
    e.bed_thickness = 31'($urandom_range(32'h0002_0000));
    e.edge_length = 31'($urandom_range(32'h0100_0000, 1));
    return e;
  endfunction

  function automatic edge_word_t noise_edge();
    edge_word_t e;
    e.edge_length = 31'($urandom);
    e.mesh_surface_z = $urandom;
    e.mesh_bedrock_z = $urandom;
    e.mesh_pond_depth = 31'($urandom);
    e.mesh_water_head = $urandom;
    e.bank_z = $urandom;
    e.bed_z = $urandom;
    e.base_width = 31'($urandom);
    e.side_slope = 31'($urandom);
    e.bed_conductivity = $urandom;
    e.bed_thickness = 31'($urandom);
    e.channel_depth = 31'($urandom);
    return e;
  endfunction

  task automatic test_directed();
    edge_word_t e;
    e = sane_edge();
    e.mesh_water_head = e.mesh_surface_z;
    send_edge(e);
    e.bed_thickness = '0;
    send_edge(e);
    e.edge_length = '0;
    send_edge(e);
    e = sane_edge();
    e.bed_conductivity = '0;
    send_edge(e);
    // Bank below bed and bedrock above bed.
    e = sane_edge();
    e.bank_z = e.bed_z - 32'sh0001_0000;
    e.mesh_bedrock_z = e.bed_z + 32'sh0000_8000;
    send_edge(e);
    // Extreme values in every field, heading for saturation both ways.
    e.edge_length = 31'h7FFF_FFFF;
    e.mesh_surface_z = 32'sh7FFF_FFFF;
    e.mesh_bedrock_z = 32'sh8000_0000;
    e.mesh_pond_depth = 31'h7FFF_FFFF;
    e.mesh_water_head = 32'sh7FFF_FFFF;
    e.bank_z = 32'sh7FFF_FFFF;
    e.bed_z = 32'sh8000_0000;
    e.base_width = 31'h7FFF_FFFF;
    e.side_slope = 31'h7FFF_FFFF;
    e.bed_conductivity = 32'hFFFF_FFFF;
    e.bed_thickness = 31'd1;
    e.channel_depth = '0;
    send_edge(e);
    e.mesh_water_head = 32'sh8000_0000;
    e.channel_depth = 31'h7FFF_FFFF;
    send_edge(e);
    e.bed_thickness = 31'h7FFF_FFFF;
    send_edge(e);
    e = noise_edge();
    e.mesh_surface_z = 32'sh8000_0000;
    e.bank_z = 32'sh8000_0000;
    send_edge(e);
    e.side_slope = '0;
    e.base_width = '0;
    send_edge(e);
    repeat (10) send_edge(noise_edge());
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_edge(($urandom_range(9) < 8) ? sane_edge() : noise_edge());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random_phase(0, 0, 400);
    test_random_phase(54, 0, 400);
    test_random_phase(0, 54, 400);
    test_random_phase(30, 30, 400);
    items.valid <= 0;
    wait (pending_flux.size() == 0);
    repeat (150) @(posedge clk);
    $display("Sent %0d edge words, checked %0d flux words, %0d saturated.",
             sent, checked, saturations);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout with %0d flux words pending", pending_flux.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

`default_nettype wire

[filelist.f]
sv/gcsf_pkg.sv
sv/gcsf_item_if.sv
sv/gcsf_flux_if.sv
sv/gcsf_front.sv
sv/gcsf_queue.sv
sv/gcsf_back.sv
sv/groundwater_channel_seepage_flux_unit.sv
sim/tb_seepage_flux_expect.sv
sim/tb.sv
